[sv/rsfc_pkg.sv]
// ----------------------------------------------------------------------------
// rsfc_pkg: shared types for the ray/sphere first contact pipeline
// Holds the per-item status flags that travel alongside the data path.
// ----------------------------------------------------------------------------
`default_nettype none

package rsfc_pkg;

    // Status that rides along with every item through the pipeline.
    typedef struct packed {
        logic degen;   // motion is zero or timeslice is zero
        logic hit;     // line passes within the radius of the centre; never set with degen
    } rsfc_flags_t;

endpackage : rsfc_pkg

`default_nettype wire

[sv/rsfc_geom.sv]
// ----------------------------------------------------------------------------
// rsfc_geom: geometry front end
// Forms C = P - S, the dot product C.U, |U|^2, the squared cross product
// |C x U|^2 and r^2 |U|^2 over seven register stages, then the hit test and
// the radicand r^2 |U|^2 - |C x U|^2 in an eighth.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfc_geom #(
    parameter int W  = 32,
    parameter int F  = 16,
    parameter int SW = 31
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       en,
    input  wire                       in_valid,
    input  wire                       in_func,
    input  wire signed [W-1:0]        in_start_x,
    input  wire signed [W-1:0]        in_start_y,
    input  wire signed [W-1:0]        in_start_z,
    input  wire signed [W-1:0]        in_motion_x,
    input  wire signed [W-1:0]        in_motion_y,
    input  wire signed [W-1:0]        in_motion_z,
    input  wire signed [W-1:0]        in_centre_x,
    input  wire signed [W-1:0]        in_centre_y,
    input  wire signed [W-1:0]        in_centre_z,
    input  wire [W-2:0]               in_radius,
    input  wire [W-2:0]               in_timeslice,
    output logic                      out_valid,
    output logic [4*W-3:0]            out_d,
    output logic signed [2*W+2:0]     out_dot,
    output logic [2*W-1:0]            out_uu,
    output logic [SW-1:0]             out_scale,
    output rsfc_pkg::rsfc_flags_t     out_flags
);

    import rsfc_pkg::*;

    localparam int CW   = W + 1;        // C = P - S
    localparam int PRW  = 2 * W + 1;    // C * U products
    localparam int DTW  = 2 * W + 3;    // dot product
    localparam int XW   = 2 * W + 2;    // cross product component, signed
    localparam int XMW  = 2 * W + 1;    // its magnitude
    localparam int XLW  = W + 1;        // low part of the magnitude
    localparam int XHW  = XMW - XLW;    // high part of the magnitude
    localparam int XSW  = 4 * W + 1;    // one squared component
    localparam int CRW  = 4 * W + 3;    // |C x U|^2
    localparam int R2W  = 2 * W - 2;    // r^2
    localparam int RLW  = W - 1;        // low part of r^2
    localparam int RHW  = R2W - RLW;    // high part of r^2
    localparam int RRW  = 4 * W - 2;    // r^2 |U|^2
    localparam int DFW  = CRW + 1;      // hit test difference

    logic signed [W-1:0] s_vec [0:2];
    logic signed [W-1:0] p_vec [0:2];
    logic signed [W-1:0] u_vec [0:2];

    assign s_vec[0] = in_start_x;
    assign s_vec[1] = in_start_y;
    assign s_vec[2] = in_start_z;
    assign p_vec[0] = in_centre_x;
    assign p_vec[1] = in_centre_y;
    assign p_vec[2] = in_centre_z;
    assign u_vec[0] = in_motion_x;
    assign u_vec[1] = in_motion_y;
    assign u_vec[2] = in_motion_z;

    // Stage 1: centre relative to start, r^2, scale.
    logic                 v1_reg;
    logic signed [CW-1:0] c1_reg [0:2];
    logic signed [W-1:0]  u1_reg [0:2];
    logic [R2W-1:0]       r2_1_reg;
    logic [SW-1:0]        scale1_reg;
    logic                 dtz1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c1_reg[i] <= CW'(p_vec[i]) - CW'(s_vec[i]);
                u1_reg[i] <= u_vec[i];
            end
            r2_1_reg   <= R2W'(in_radius) * R2W'(in_radius);
            scale1_reg <= in_func ? SW'(in_timeslice) : (SW'(1) << F);
            dtz1_reg   <= (in_timeslice == '0);
        end
    end

    // Stage 2: all products of C and U.
    logic                  v2_reg;
    logic signed [PRW-1:0] cu2_reg [0:2];
    logic [2*W-1:0]        uq2_reg [0:2];
    logic signed [PRW-1:0] pa2_reg [0:2];
    logic signed [PRW-1:0] pb2_reg [0:2];
    logic [R2W-1:0]        r2_2_reg;
    logic [SW-1:0]         scale2_reg;
    logic                  dtz2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                cu2_reg[i] <= PRW'(c1_reg[i]) * PRW'(u1_reg[i]);
                uq2_reg[i] <= (2*W)'(u1_reg[i]) * (2*W)'(u1_reg[i]);
                pa2_reg[i] <= PRW'(c1_reg[(i + 1) % 3]) * PRW'(u1_reg[(i + 2) % 3]);
                pb2_reg[i] <= PRW'(c1_reg[(i + 2) % 3]) * PRW'(u1_reg[(i + 1) % 3]);
            end
            r2_2_reg   <= r2_1_reg;
            scale2_reg <= scale1_reg;
            dtz2_reg   <= dtz1_reg;
        end
    end

    // Stage 3: sums and cross product components.
    logic                  v3_reg;
    logic signed [DTW-1:0] dot3_reg;
    logic [2*W-1:0]        uu3_reg;
    logic signed [XW-1:0]  x3_reg [0:2];
    logic [R2W-1:0]        r2_3_reg;
    logic [SW-1:0]         scale3_reg;
    logic                  dtz3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dot3_reg <= DTW'(cu2_reg[0]) + DTW'(cu2_reg[1]) + DTW'(cu2_reg[2]);
            uu3_reg  <= uq2_reg[0] + uq2_reg[1] + uq2_reg[2];
            for (int i = 0; i < 3; i++) begin
                x3_reg[i] <= XW'(pa2_reg[i]) - XW'(pb2_reg[i]);
            end
            r2_3_reg   <= r2_2_reg;
            scale3_reg <= scale2_reg;
            dtz3_reg   <= dtz2_reg;
        end
    end

    // Stage 4: magnitudes of the cross components, partial products of r^2 |U|^2.
    logic                  v4_reg;
    logic [XMW-1:0]        xm4_reg [0:2];
    logic [RLW+W-1:0]      rll4_reg;
    logic [RLW+W-1:0]      rlh4_reg;
    logic [RHW+W-1:0]      rhl4_reg;
    logic [RHW+W-1:0]      rhh4_reg;
    logic signed [DTW-1:0] dot4_reg;
    logic [2*W-1:0]        uu4_reg;
    logic [SW-1:0]         scale4_reg;
    logic                  degen4_reg;
    logic signed [XW-1:0]  xneg3 [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            xneg3[i] = -x3_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                xm4_reg[i] <= x3_reg[i][XW-1] ? xneg3[i][XMW-1:0] : x3_reg[i][XMW-1:0];
            end
            rll4_reg   <= (RLW+W)'(r2_3_reg[RLW-1:0]) * (RLW+W)'(uu3_reg[W-1:0]);
            rlh4_reg   <= (RLW+W)'(r2_3_reg[RLW-1:0]) * (RLW+W)'(uu3_reg[2*W-1:W]);
            rhl4_reg   <= (RHW+W)'(r2_3_reg[R2W-1:RLW]) * (RHW+W)'(uu3_reg[W-1:0]);
            rhh4_reg   <= (RHW+W)'(r2_3_reg[R2W-1:RLW]) * (RHW+W)'(uu3_reg[2*W-1:W]);
            dot4_reg   <= dot3_reg;
            uu4_reg    <= uu3_reg;
            scale4_reg <= scale3_reg;
            degen4_reg <= (uu3_reg == '0) || dtz3_reg;
        end
    end

    // Stage 5: r^2 |U|^2 assembled, partial squares of the cross components.
    logic                  v5_reg;
    logic [RRW-1:0]        rr5_reg;
    logic [2*XLW-1:0]      xll5_reg [0:2];
    logic [XHW+XLW-1:0]    xhl5_reg [0:2];
    logic [2*XHW-1:0]      xhh5_reg [0:2];
    logic signed [DTW-1:0] dot5_reg;
    logic [2*W-1:0]        uu5_reg;
    logic [SW-1:0]         scale5_reg;
    logic                  degen5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rr5_reg <= (RRW'(rhh4_reg) << (RLW + W)) + (RRW'(rhl4_reg) << RLW)
                     + (RRW'(rlh4_reg) << W) + RRW'(rll4_reg);
            for (int i = 0; i < 3; i++) begin
                xll5_reg[i] <= (2*XLW)'(xm4_reg[i][XLW-1:0])
                             * (2*XLW)'(xm4_reg[i][XLW-1:0]);
                xhl5_reg[i] <= (XHW+XLW)'(xm4_reg[i][XMW-1:XLW])
                             * (XHW+XLW)'(xm4_reg[i][XLW-1:0]);
                xhh5_reg[i] <= (2*XHW)'(xm4_reg[i][XMW-1:XLW])
                             * (2*XHW)'(xm4_reg[i][XMW-1:XLW]);
            end
            dot5_reg   <= dot4_reg;
            uu5_reg    <= uu4_reg;
            scale5_reg <= scale4_reg;
            degen5_reg <= degen4_reg;
        end
    end

    // Stage 6: one squared component per lane.
    logic                  v6_reg;
    logic [XSW-1:0]        xsq6_reg [0:2];
    logic [RRW-1:0]        rr6_reg;
    logic signed [DTW-1:0] dot6_reg;
    logic [2*W-1:0]        uu6_reg;
    logic [SW-1:0]         scale6_reg;
    logic                  degen6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                xsq6_reg[i] <= (XSW'(xhh5_reg[i]) << (2 * XLW))
                             + (XSW'(xhl5_reg[i]) << (XLW + 1))
                             + XSW'(xll5_reg[i]);
            end
            rr6_reg    <= rr5_reg;
            dot6_reg   <= dot5_reg;
            uu6_reg    <= uu5_reg;
            scale6_reg <= scale5_reg;
            degen6_reg <= degen5_reg;
        end
    end

    // Stage 7: |C x U|^2.
    logic                  v7_reg;
    logic [CRW-1:0]        cr7_reg;
    logic [RRW-1:0]        rr7_reg;
    logic signed [DTW-1:0] dot7_reg;
    logic [2*W-1:0]        uu7_reg;
    logic [SW-1:0]         scale7_reg;
    logic                  degen7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v7_reg <= 1'b0;
        end else if (en) begin
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cr7_reg    <= CRW'(xsq6_reg[0]) + CRW'(xsq6_reg[1]) + CRW'(xsq6_reg[2]);
            rr7_reg    <= rr6_reg;
            dot7_reg   <= dot6_reg;
            uu7_reg    <= uu6_reg;
            scale7_reg <= scale6_reg;
            degen7_reg <= degen6_reg;
        end
    end

    // Stage 8: hit test; a grazing line (difference zero) is a hit.
    logic [DFW-1:0] diff7;
    logic           hit7;

    assign diff7 = DFW'(rr7_reg) - DFW'(cr7_reg);
    assign hit7  = !diff7[DFW-1] && !degen7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= v7_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_d           <= hit7 ? diff7[RRW-1:0] : '0;
            out_dot         <= dot7_reg;
            out_uu          <= uu7_reg;
            out_scale       <= scale7_reg;
            out_flags.degen <= degen7_reg;
            out_flags.hit   <= hit7;
        end
    end

endmodule : rsfc_geom

`default_nettype wire

[sv/rsfc_sqrt.sv]
// ----------------------------------------------------------------------------
// rsfc_sqrt: pipelined integer square root
// One result bit per stage, restoring digit recurrence; side data is delayed
// along with the root.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfc_sqrt #(
    parameter int W      = 32,
    parameter int DATA_W = 191
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       en,
    input  wire                       in_valid,
    input  wire [4*W-3:0]             in_d,
    input  wire [DATA_W-1:0]          in_data,
    input  rsfc_pkg::rsfc_flags_t     in_flags,
    output logic                      out_valid,
    output logic [2*W-2:0]            out_root,
    output logic [DATA_W-1:0]         out_data,
    output rsfc_pkg::rsfc_flags_t     out_flags
);

    import rsfc_pkg::*;

    localparam int N  = 2 * W - 1;   // root bits, one stage each
    localparam int DW = 4 * W - 2;   // radicand bits
    localparam int TW = DW + 1;

    logic              v_reg     [1:N];
    logic [DW-1:0]     rem_reg   [1:N];
    logic [N-1:0]      root_reg  [1:N];
    logic [DATA_W-1:0] data_reg  [1:N];
    rsfc_flags_t       flags_reg [1:N];

    for (genvar j = 1; j <= N; j++) begin : g_stage
        localparam int K = N - j;   // root bit decided here

        logic              v_prev;
        logic [DW-1:0]     rem_prev;
        logic [N-1:0]      root_prev;
        logic [DATA_W-1:0] data_prev;
        rsfc_flags_t       flags_prev;
        logic [TW-1:0]     trial;
        logic              take;

        if (j == 1) begin : g_first
            assign v_prev     = in_valid;
            assign rem_prev   = in_d;
            assign root_prev  = '0;
            assign data_prev  = in_data;
            assign flags_prev = in_flags;
        end else begin : g_next
            assign v_prev     = v_reg[j-1];
            assign rem_prev   = rem_reg[j-1];
            assign root_prev  = root_reg[j-1];
            assign data_prev  = data_reg[j-1];
            assign flags_prev = flags_reg[j-1];
        end

        // (2 * root + 2^K) * 2^K with root holding only the bits above K.
        assign trial = (TW'(root_prev) << (K + 1)) | (TW'(1) << (2 * K));
        assign take  = ({1'b0, rem_prev} >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[j] <= 1'b0;
            end else if (en) begin
                v_reg[j] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j]   <= take ? (rem_prev - trial[DW-1:0]) : rem_prev;
                root_reg[j]  <= take ? (root_prev | (N'(1) << K)) : root_prev;
                data_reg[j]  <= data_prev;
                flags_reg[j] <= flags_prev;
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_root  = root_reg[N];
    assign out_data  = data_reg[N];
    assign out_flags = flags_reg[N];

endmodule : rsfc_sqrt

`default_nettype wire

[sv/rsfc_div.sv]
// ----------------------------------------------------------------------------
// rsfc_div: scaling and floor division back end
// Forms (C.U - root) * scale, divides it by |U|^2 rounding toward minus
// infinity with one quotient bit per stage, and saturates to the output range.
// ----------------------------------------------------------------------------
`default_nettype none

module rsfc_div #(
    parameter int W  = 32,
    parameter int SW = 31
) (
    input  wire                       aclk,
    input  wire                       aresetn,
    input  wire                       en,
    input  wire                       in_valid,
    input  wire signed [2*W+2:0]      in_dot,
    input  wire [2*W-2:0]             in_root,
    input  wire [2*W-1:0]             in_uu,
    input  wire [SW-1:0]              in_scale,
    input  rsfc_pkg::rsfc_flags_t     in_flags,
    output logic                      out_valid,
    output logic [W-1:0]              out_time,
    output rsfc_pkg::rsfc_flags_t     out_flags
);

    import rsfc_pkg::*;

    localparam int NW  = 2 * W + 3;    // numerator, signed
    localparam int MW  = 2 * W + 2;    // its magnitude
    localparam int MLW = W + 1;        // low part of the magnitude
    localparam int MHW = MW - MLW;     // high part of the magnitude
    localparam int PW  = MW + SW;      // scaled magnitude
    localparam int RMW = PW + 1;       // dividend and running remainder
    localparam logic [W-1:0] NEG_LIM = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] POS_LIM = {1'b0, {(W-1){1'b1}}};

    // Stage 1: numerator.
    logic                 v1_reg;
    logic signed [NW-1:0] num1_reg;
    logic [2*W-1:0]       uu1_reg;
    logic [SW-1:0]        scale1_reg;
    rsfc_flags_t          flags1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            num1_reg   <= in_dot - $signed(NW'(in_root));
            uu1_reg    <= in_uu;
            scale1_reg <= in_scale;
            flags1_reg <= in_flags;
        end
    end

    // Stage 2: sign and magnitude.
    logic                 v2_reg;
    logic                 neg2_reg;
    logic [MW-1:0]        mag2_reg;
    logic [2*W-1:0]       uu2_reg;
    logic [SW-1:0]        scale2_reg;
    rsfc_flags_t          flags2_reg;
    logic signed [NW-1:0] numneg1;

    assign numneg1 = -num1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg2_reg   <= num1_reg[NW-1];
            mag2_reg   <= num1_reg[NW-1] ? numneg1[MW-1:0] : num1_reg[MW-1:0];
            uu2_reg    <= uu1_reg;
            scale2_reg <= scale1_reg;
            flags2_reg <= flags1_reg;
        end
    end

    // Stage 3: partial products of magnitude and scale.
    logic               v3_reg;
    logic               neg3_reg;
    logic [MLW+SW-1:0]  pl3_reg;
    logic [MHW+SW-1:0]  ph3_reg;
    logic [2*W-1:0]     uu3_reg;
    rsfc_flags_t        flags3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg3_reg   <= neg2_reg;
            pl3_reg    <= (MLW+SW)'(mag2_reg[MLW-1:0]) * (MLW+SW)'(scale2_reg);
            ph3_reg    <= (MHW+SW)'(mag2_reg[MW-1:MLW]) * (MHW+SW)'(scale2_reg);
            uu3_reg    <= uu2_reg;
            flags3_reg <= flags2_reg;
        end
    end

    // Stage 4: scaled magnitude.
    logic           v4_reg;
    logic           neg4_reg;
    logic [PW-1:0]  prod4_reg;
    logic [2*W-1:0] uu4_reg;
    rsfc_flags_t    flags4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg4_reg   <= neg3_reg;
            prod4_reg  <= (PW'(ph3_reg) << MLW) + PW'(pl3_reg);
            uu4_reg    <= uu3_reg;
            flags4_reg <= flags3_reg;
        end
    end

    // Stage 5: a negative quotient rounds its magnitude up, so floor holds.
    logic           v5_reg;
    logic           neg5_reg;
    logic [RMW-1:0] dvd5_reg;
    logic [2*W-1:0] uu5_reg;
    rsfc_flags_t    flags5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v5_reg <= 1'b0;
        end else if (en) begin
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg5_reg   <= neg4_reg;
            dvd5_reg   <= neg4_reg ? (RMW'(prod4_reg) + RMW'(uu4_reg) - RMW'(1))
                                   : RMW'(prod4_reg);
            uu5_reg    <= uu4_reg;
            flags5_reg <= flags4_reg;
        end
    end

    // Stage 6: quotients of 2^W or more saturate either way.
    logic           v6_reg;
    logic           neg6_reg;
    logic           ovf6_reg;
    logic [RMW-1:0] rem6_reg;
    logic [2*W-1:0] uu6_reg;
    rsfc_flags_t    flags6_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v6_reg <= 1'b0;
        end else if (en) begin
            v6_reg <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg6_reg   <= neg5_reg;
            ovf6_reg   <= (dvd5_reg >= (RMW'(uu5_reg) << W));
            rem6_reg   <= dvd5_reg;
            uu6_reg    <= uu5_reg;
            flags6_reg <= flags5_reg;
        end
    end

    // Quotient stages, most significant bit first.
    logic           qv_reg     [1:W];
    logic           qneg_reg   [1:W];
    logic           qovf_reg   [1:W];
    logic [RMW-1:0] qrem_reg   [1:W];
    logic [W-1:0]   q_reg      [1:W];
    logic [2*W-1:0] quu_reg    [1:W];
    rsfc_flags_t    qflags_reg [1:W];

    for (genvar j = 1; j <= W; j++) begin : g_step
        localparam int K = W - j;

        logic           v_prev;
        logic           neg_prev;
        logic           ovf_prev;
        logic [RMW-1:0] rem_prev;
        logic [W-1:0]   q_prev;
        logic [2*W-1:0] uu_prev;
        rsfc_flags_t    flags_prev;
        logic [RMW-1:0] dsh;
        logic           take;

        if (j == 1) begin : g_first
            assign v_prev     = v6_reg;
            assign neg_prev   = neg6_reg;
            assign ovf_prev   = ovf6_reg;
            assign rem_prev   = rem6_reg;
            assign q_prev     = '0;
            assign uu_prev    = uu6_reg;
            assign flags_prev = flags6_reg;
        end else begin : g_next
            assign v_prev     = qv_reg[j-1];
            assign neg_prev   = qneg_reg[j-1];
            assign ovf_prev   = qovf_reg[j-1];
            assign rem_prev   = qrem_reg[j-1];
            assign q_prev     = q_reg[j-1];
            assign uu_prev    = quu_reg[j-1];
            assign flags_prev = qflags_reg[j-1];
        end

        assign dsh  = RMW'(uu_prev) << K;
        assign take = (rem_prev >= dsh);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                qv_reg[j] <= 1'b0;
            end else if (en) begin
                qv_reg[j] <= v_prev;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                qneg_reg[j]   <= neg_prev;
                qovf_reg[j]   <= ovf_prev;
                qrem_reg[j]   <= take ? (rem_prev - dsh) : rem_prev;
                q_reg[j]      <= take ? (q_prev | (W'(1) << K)) : q_prev;
                quu_reg[j]    <= uu_prev;
                qflags_reg[j] <= flags_prev;
            end
        end
    end

    // Final stage: saturate, apply sign, zero on a miss.
    logic [W-1:0] qfull;
    logic [W-1:0] mag_sat;
    logic [W-1:0] time_val;

    always_comb begin
        qfull = qovf_reg[W] ? '1 : q_reg[W];
        if (qneg_reg[W]) begin
            mag_sat  = (qfull > NEG_LIM) ? NEG_LIM : qfull;
            time_val = -mag_sat;
        end else begin
            mag_sat  = (qfull > POS_LIM) ? POS_LIM : qfull;
            time_val = mag_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid <= 1'b0;
        end else if (en) begin
            out_valid <= qv_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_time  <= qflags_reg[W].hit ? time_val : '0;
            out_flags <= qflags_reg[W];
        end
    end

endmodule : rsfc_div

`default_nettype wire

[sv/ray_sphere_first_contact_unit.sv]
// Throughput: one item per cycle while no result is stuck at the output; the
// square root and the divider are fully pipelined, one result bit per stage,
// so no unit is shared between items.
// Reset: aresetn is synchronous and active low; it clears every stage valid bit
// and the output register, the data registers keep whatever they held.
// ----------------------------------------------------------------------------
// ray_sphere_first_contact_unit: first contact of a moving point with a sphere
// Exact wide-integer closest approach test and first contact time in signed
// fixed point, as a deep pipeline with an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_sphere_first_contact_unit #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_func,
    input  wire signed [COORD_WIDTH-1:0] s_start_x,
    input  wire signed [COORD_WIDTH-1:0] s_start_y,
    input  wire signed [COORD_WIDTH-1:0] s_start_z,
    input  wire signed [COORD_WIDTH-1:0] s_motion_x,
    input  wire signed [COORD_WIDTH-1:0] s_motion_y,
    input  wire signed [COORD_WIDTH-1:0] s_motion_z,
    input  wire signed [COORD_WIDTH-1:0] s_centre_x,
    input  wire signed [COORD_WIDTH-1:0] s_centre_y,
    input  wire signed [COORD_WIDTH-1:0] s_centre_z,
    input  wire [COORD_WIDTH-2:0]        s_radius,
    input  wire [COORD_WIDTH-2:0]        s_timeslice,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic                         m_hit,
    output logic signed [COORD_WIDTH-1:0] m_contact_time,
    output logic                         m_degenerate
);

    import rsfc_pkg::*;

    localparam int W      = COORD_WIDTH;
    // The scale is either the timeslice or one in the fixed point format.
    localparam int SW     = (W - 1 > FRAC_BITS + 1) ? (W - 1) : (FRAC_BITS + 1);
    localparam int DTW    = 2 * W + 3;
    localparam int UUW    = 2 * W;
    localparam int DATA_W = DTW + UUW + SW;

    // The whole pipeline moves as one. It only holds when its last stage has
    // a finished item and the output register still holds an earlier one that
    // is not being taken; a bubble in the last stage lets new transfers in, so the
    // block keeps accepting while a result waits at the output.
    logic        en;
    logic        div_valid;
    logic [W-1:0] div_time;
    rsfc_flags_t div_flags;

    assign en      = !div_valid || !m_valid || m_ready;
    assign s_ready = en;

    // Geometry: closest approach test and radicand.
    logic               geo_valid;
    logic [4*W-3:0]     geo_d;
    logic signed [DTW-1:0] geo_dot;
    logic [UUW-1:0]     geo_uu;
    logic [SW-1:0]      geo_scale;
    rsfc_flags_t        geo_flags;

    rsfc_geom #(
        .W  (W),
        .F  (FRAC_BITS),
        .SW (SW)
    ) u_geom (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (en),
        .in_valid     (s_valid && s_ready),
        .in_func      (s_func),
        .in_start_x   (s_start_x),
        .in_start_y   (s_start_y),
        .in_start_z   (s_start_z),
        .in_motion_x  (s_motion_x),
        .in_motion_y  (s_motion_y),
        .in_motion_z  (s_motion_z),
        .in_centre_x  (s_centre_x),
        .in_centre_y  (s_centre_y),
        .in_centre_z  (s_centre_z),
        .in_radius    (s_radius),
        .in_timeslice (s_timeslice),
        .out_valid    (geo_valid),
        .out_d        (geo_d),
        .out_dot      (geo_dot),
        .out_uu       (geo_uu),
        .out_scale    (geo_scale),
        .out_flags    (geo_flags)
    );

    // Square root of the radicand; the operands of the division ride along.
    logic               sq_valid;
    logic [2*W-2:0]     sq_root;
    logic [DATA_W-1:0]  sq_data;
    rsfc_flags_t        sq_flags;

    rsfc_sqrt #(
        .W      (W),
        .DATA_W (DATA_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (geo_valid),
        .in_d      (geo_d),
        .in_data   ({geo_dot, geo_uu, geo_scale}),
        .in_flags  (geo_flags),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_data  (sq_data),
        .out_flags (sq_flags)
    );

    // Scaling, floor division by |U|^2 and saturation.
    rsfc_div #(
        .W  (W),
        .SW (SW)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_dot    ($signed(sq_data[DATA_W-1:UUW+SW])),
        .in_root   (sq_root),
        .in_uu     (sq_data[UUW+SW-1:SW]),
        .in_scale  (sq_data[SW-1:0]),
        .in_flags  (sq_flags),
        .out_valid (div_valid),
        .out_time  (div_time),
        .out_flags (div_flags)
    );

    // Output register. It loads whenever the last stage moves a finished item
    // out, which en only allows when the register is empty or being read.
    logic m_valid_next;

    always_comb begin
        m_valid_next = m_valid;
        if (div_valid && en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else begin
            m_valid <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (div_valid && en) begin
            m_hit          <= div_flags.hit;
            m_degenerate   <= div_flags.degen;
            m_contact_time <= div_time;
        end
    end

`ifndef SYNTHESIS
    // Input transfers are only refused while a result is stuck at the output.
    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input refused without an output stall");

    // A degenerate query never reports a hit.
    a_degen_no_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_degenerate) |-> !m_hit)
        else $error("degenerate result flagged as hit");

    // A miss always carries a zero time.
    a_miss_zero_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_hit) |-> (m_contact_time == '0))
        else $error("miss with nonzero contact time");
`endif

endmodule : ray_sphere_first_contact_unit

`default_nettype wire
